@@ sv/afd_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants of the audio frame deframer
// no dependencies
package afd_pkg;

  localparam int unsigned HDR_BYTES  = 20;
  localparam int unsigned MUL_STEPS  = 19;
  localparam int unsigned PROD_W     = 86;
  localparam int unsigned DIV_DIGITS = 7;

  localparam logic [31:0] FRAME_MAGIC = 32'h4D52_4641;
  localparam logic [18:0] LEN_CAP     = 19'd262144;
  localparam logic [29:0] NS_PER_SEC  = 30'd1000000000;
  // 1e9 is 2^9 times this odd part
  localparam logic [20:0] PTS_DIV     = 21'd1953125;
  // floor(2^32 / PTS_DIV), the estimate is low by at most one
  localparam logic [11:0] PTS_RECIP   = 12'd2199;

  localparam logic [7:0]  CH_RST   = 8'd2;
  localparam logic [3:0]  SB_RST   = 4'd4;
  localparam logic [18:0] RATE_RST = 19'd48000;

  localparam logic [1:0] CFG_CHANNELS = 2'd0;
  localparam logic [1:0] CFG_SAMPLEB  = 2'd1;
  localparam logic [1:0] CFG_RATE     = 2'd2;
  localparam logic [1:0] CFG_MAXLEN   = 2'd3;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_DROP    = 2'd2;

  typedef enum logic [2:0] {
    ST_SEARCH,
    ST_MUL,
    ST_DIV,
    ST_EMIT,
    ST_COPY,
    ST_DISCARD
  } state_e;

  typedef struct packed {
    logic win_shift;
    logic capture;
    logic mul_step;
    logic div_step;
    logic emit;
    logic copy_step;
    logic disc_step;
  } cmd_t;

  typedef struct packed {
    logic hdr_hit;
    logic cnt_zero;
    logic frames_zero;
    logic len_zero;
    logic copy_one;
    logic disc_zero;
    logic disc_one;
    logic slot_free;
  } sts_t;

endpackage

@@ sv/afd_if.sv @@
`timescale 1ns / 1ps
// byte input and result output channels of the deframer
// no dependencies
interface afd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface afd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [62:0] pts;
  logic [18:0] frame_count;
  logic [7:0]  data_byte;
  logic        last;
  modport source (output valid, output kind, output pts, output frame_count,
                  output data_byte, output last, input ready);
  modport sink (input valid, input kind, input pts, input frame_count,
                input data_byte, input last, output ready);
endinterface

@@ sv/audio_frame_deframer.sv @@
`timescale 1ns / 1ps
// channel    | dir | payload                                   | accepted when
// in_if      | in  | in_byte                                   | valid & ready
// out_if     | out | kind, pts, frame_count, data_byte, last   | valid & ready
// cfg        | in  | cfg_idx_i, cfg_data_i                     | cfg_we_i
//
// search and tail bytes are accepted whenever offered.
// a good header stalls input through 19 shift-add multiply steps (one per sample
// rate bit), then a divide by 1e9 in seven 11-bit digits (estimate then
// correct), then until the result register is loaded, which waits while it
// is still full; the frame divide runs beside the multiply.
// payload bytes wait only while the result register is full and not taken.
// reset leaves the window empty and the block searching; no clearing pass.
// depends on afd_pkg, afd_if, afd_ctrl, afd_dpath
module audio_frame_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  afd_in_if.sink      in_if,
  afd_out_if.source   out_if,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [18:0] cfg_data_i
);

  afd_pkg::cmd_t cmd;
  afd_pkg::sts_t sts;

  afd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  afd_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_byte_i     (in_if.in_byte),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_if.valid),
    .out_ready_i   (out_if.ready),
    .kind_o        (out_if.kind),
    .pts_o         (out_if.pts),
    .frame_count_o (out_if.frame_count),
    .data_byte_o   (out_if.data_byte),
    .last_o        (out_if.last)
  );

endmodule

@@ sv/afd_ctrl.sv @@
`timescale 1ns / 1ps
// deframer controller: phase and arithmetic sequencing
// depends on afd_pkg
module afd_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  afd_pkg::sts_t   sts_i,
  output afd_pkg::cmd_t   cmd_o
);

  afd_pkg::state_e state_q, state_d;
  logic acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= afd_pkg::ST_SEARCH;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    unique case (state_q)
      afd_pkg::ST_SEARCH, afd_pkg::ST_DISCARD: in_ready_o = 1'b1;
      afd_pkg::ST_COPY: in_ready_o = sts_i.slot_free;
      default: in_ready_o = 1'b0;
    endcase
  end

  assign acc = in_valid_i & in_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      afd_pkg::ST_SEARCH: begin
        if (acc && sts_i.hdr_hit) state_d = afd_pkg::ST_MUL;
      end
      afd_pkg::ST_MUL: begin
        if (sts_i.cnt_zero) state_d = afd_pkg::ST_DIV;
      end
      afd_pkg::ST_DIV: begin
        if (sts_i.cnt_zero) state_d = afd_pkg::ST_EMIT;
      end
      afd_pkg::ST_EMIT: begin
        if (sts_i.slot_free) begin
          if (!sts_i.frames_zero) state_d = afd_pkg::ST_COPY;
          else if (sts_i.len_zero) state_d = afd_pkg::ST_SEARCH;
          else state_d = afd_pkg::ST_DISCARD;
        end
      end
      afd_pkg::ST_COPY: begin
        if (acc && sts_i.copy_one)
          state_d = sts_i.disc_zero ? afd_pkg::ST_SEARCH : afd_pkg::ST_DISCARD;
      end
      afd_pkg::ST_DISCARD: begin
        if (acc && sts_i.disc_one) state_d = afd_pkg::ST_SEARCH;
      end
      default: state_d = afd_pkg::ST_SEARCH;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.win_shift = acc && (state_q == afd_pkg::ST_SEARCH);
    cmd_o.capture   = acc && (state_q == afd_pkg::ST_SEARCH) && sts_i.hdr_hit;
    cmd_o.mul_step  = (state_q == afd_pkg::ST_MUL);
    cmd_o.div_step  = (state_q == afd_pkg::ST_DIV);
    cmd_o.emit      = (state_q == afd_pkg::ST_EMIT) && sts_i.slot_free;
    cmd_o.copy_step = acc && (state_q == afd_pkg::ST_COPY);
    cmd_o.disc_step = acc && (state_q == afd_pkg::ST_DISCARD);
  end

endmodule

@@ sv/afd_dpath.sv @@
`timescale 1ns / 1ps
// deframer datapath: header window, config, serial multiply and divides, result register
// depends on afd_pkg
module afd_dpath (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [18:0]   cfg_data_i,
  input  logic [7:0]    in_byte_i,
  input  afd_pkg::cmd_t cmd_i,
  output afd_pkg::sts_t sts_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [1:0]    kind_o,
  output logic [62:0]   pts_o,
  output logic [18:0]   frame_count_o,
  output logic [7:0]    data_byte_o,
  output logic          last_o
);

  logic [7:0]  ch_q;
  logic [3:0]  sb_q;
  logic [18:0] rate_q;
  logic [18:0] maxlen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q     <= afd_pkg::CH_RST;
      sb_q     <= afd_pkg::SB_RST;
      rate_q   <= afd_pkg::RATE_RST;
      maxlen_q <= afd_pkg::LEN_CAP;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        afd_pkg::CFG_CHANNELS: ch_q     <= cfg_data_i[7:0];
        afd_pkg::CFG_SAMPLEB:  sb_q     <= cfg_data_i[3:0];
        afd_pkg::CFG_RATE:     rate_q   <= cfg_data_i;
        afd_pkg::CFG_MAXLEN:   maxlen_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective settings: zero channels, sample bytes or rate mean the reset value; limit capped
  logic [7:0]  ch_eff;
  logic [3:0]  sb_eff;
  logic [18:0] rate_eff;
  logic [18:0] limit;
  assign ch_eff   = (ch_q == 8'd0) ? afd_pkg::CH_RST : ch_q;
  assign sb_eff   = (sb_q == 4'd0) ? afd_pkg::SB_RST : sb_q;
  assign rate_eff = (rate_q == 19'd0) ? afd_pkg::RATE_RST : rate_q;
  assign limit    = (maxlen_q > afd_pkg::LEN_CAP) ? afd_pkg::LEN_CAP : maxlen_q;

  // header window, oldest byte at index 0
  logic [7:0] win_q [afd_pkg::HDR_BYTES];
  logic [7:0] nwin  [afd_pkg::HDR_BYTES];
  logic [4:0] fill_q;

  always_comb begin
    for (int i = 0; i < afd_pkg::HDR_BYTES - 1; i++) nwin[i] = win_q[i+1];
    nwin[afd_pkg::HDR_BYTES-1] = in_byte_i;
  end

  logic [31:0] magic;
  logic [63:0] ts;
  logic [31:0] len;
  logic        full_next;
  logic        good;
  assign magic = {nwin[3], nwin[2], nwin[1], nwin[0]};
  assign ts    = {nwin[11], nwin[10], nwin[9], nwin[8], nwin[7], nwin[6], nwin[5], nwin[4]};
  assign len   = {nwin[15], nwin[14], nwin[13], nwin[12]};
  assign full_next = (fill_q == 5'(afd_pkg::HDR_BYTES - 1));
  assign good = (magic == afd_pkg::FRAME_MAGIC) && (len <= {13'd0, limit});

  always_ff @(posedge clk_i) begin
    if (cmd_i.win_shift) begin
      for (int i = 0; i < afd_pkg::HDR_BYTES; i++) win_q[i] <= nwin[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (cmd_i.win_shift) begin
      if (!full_next) fill_q <= fill_q + 5'd1;
      else if (good) fill_q <= '0;
    end
  end

  // arithmetic: ts*rate by shift-add, len/(ch*bps) bit serial beside it,
  // then /1e9 as /2^9 and seven 11-bit digits by reciprocal estimate
  logic [6:0]                    cnt_q;
  logic [afd_pkg::PROD_W-1:0]    prod_q;
  logic [18:0]                   rsh_q;
  logic [63:0]                   ts_q;
  logic [18:0]                   len_q;
  logic [11:0]                   dv_q;
  logic [18:0]                   fq_q;
  logic [11:0]                   frem_q;
  logic [20:0]                   drem_q;
  logic [31:0]                   dy_q;
  logic [10:0]                   qe_q;
  logic [62:0]                   quo_q;
  logic [18:0]                   copy_q;
  logic [18:0]                   disc_q;

  logic [12:0] fr;
  logic        fge;
  logic [30:0] fcopy;
  logic [31:0] dy;
  logic [42:0] dyr;
  logic [31:0] dqd;
  logic [31:0] dr0;
  logic        dfix;
  assign fr    = {frem_q, fq_q[18]};
  assign fge   = fr >= {1'b0, dv_q};
  assign fcopy = fq_q * dv_q;
  assign dy    = {drem_q, prod_q[afd_pkg::PROD_W-1 -: 11]};
  assign dyr   = dy * afd_pkg::PTS_RECIP;
  assign dqd   = qe_q * afd_pkg::PTS_DIV;
  assign dr0   = dy_q - dqd;
  assign dfix  = dr0 >= {11'd0, afd_pkg::PTS_DIV};

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cnt_q  <= 7'(afd_pkg::MUL_STEPS - 1);
      prod_q <= '0;
      rsh_q  <= rate_eff;
      ts_q   <= ts;
      len_q  <= len[18:0];
      dv_q   <= ch_eff * sb_eff;
      fq_q   <= len[18:0];
      frem_q <= '0;
    end else if (cmd_i.mul_step) begin
      prod_q <= {prod_q[afd_pkg::PROD_W-2:0], 1'b0}
                + (rsh_q[18] ? {22'd0, ts_q} : '0);
      rsh_q  <= {rsh_q[17:0], 1'b0};
      fq_q   <= {fq_q[17:0], fge};
      frem_q <= fge ? 12'(fr - {1'b0, dv_q}) : fr[11:0];
      drem_q <= '0;
      quo_q  <= '0;
      cnt_q  <= (cnt_q == 7'd0) ? 7'(2 * afd_pkg::DIV_DIGITS - 1) : cnt_q - 7'd1;
    end else if (cmd_i.div_step) begin
      if (cnt_q[0]) begin
        // estimate the digit and bring the next chunk up
        dy_q   <= dy;
        qe_q   <= dyr[42:32];
        prod_q <= {prod_q[afd_pkg::PROD_W-12:0], 11'd0};
      end else begin
        drem_q <= dfix ? 21'(dr0 - {11'd0, afd_pkg::PTS_DIV}) : dr0[20:0];
        quo_q  <= {quo_q[51:0], dfix ? qe_q + 11'd1 : qe_q};
      end
      cnt_q <= cnt_q - 7'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      copy_q <= fcopy[18:0];
      disc_q <= (fq_q == 19'd0) ? len_q : len_q - fcopy[18:0];
    end else begin
      if (cmd_i.copy_step) copy_q <= copy_q - 19'd1;
      if (cmd_i.disc_step) disc_q <= disc_q - 19'd1;
    end
  end

  // result register
  logic        ovalid_q;
  logic [1:0]  kind_q;
  logic [62:0] pts_q;
  logic [18:0] fc_q;
  logic [7:0]  db_q;
  logic        last_q;
  logic        slot_free;
  assign slot_free = !ovalid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.emit || cmd_i.copy_step) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      kind_q <= (fq_q == 19'd0) ? afd_pkg::KIND_DROP : afd_pkg::KIND_HEADER;
      pts_q  <= (fq_q == 19'd0) ? '0 : quo_q;
      fc_q   <= fq_q;
      db_q   <= '0;
      last_q <= 1'b0;
    end else if (cmd_i.copy_step) begin
      kind_q <= afd_pkg::KIND_PAYLOAD;
      pts_q  <= '0;
      fc_q   <= '0;
      db_q   <= in_byte_i;
      last_q <= (copy_q == 19'd1);
    end
  end

  assign out_valid_o   = ovalid_q;
  assign kind_o        = kind_q;
  assign pts_o         = pts_q;
  assign frame_count_o = fc_q;
  assign data_byte_o   = db_q;
  assign last_o        = last_q;

  assign sts_o.hdr_hit     = full_next && good;
  assign sts_o.cnt_zero    = (cnt_q == 7'd0);
  assign sts_o.frames_zero = (fq_q == 19'd0);
  assign sts_o.len_zero    = (len_q == 19'd0);
  assign sts_o.copy_one    = (copy_q == 19'd1);
  assign sts_o.disc_zero   = (disc_q == 19'd0);
  assign sts_o.disc_one    = (disc_q == 19'd1);
  assign sts_o.slot_free   = slot_free;

endmodule

@@ bench/audio_frame_deframer_tb.sv @@
`timescale 1ns / 1ps
// self-checking bench for audio_frame_deframer: packets and noise bytes in,
// results checked against an in-bench model of the header search and copy
// depends on afd_pkg, afd_if and the deframer rtl
module audio_frame_deframer_tb;

  typedef struct packed {
    logic [1:0]  kind;
    logic [62:0] pts;
    logic [18:0] frame_count;
    logic [7:0]  data_byte;
    logic        last;
  } result_t;

  typedef enum logic [1:0] {SCAN, PASS, SKIP} walk_e;

  typedef struct {
    int          noise;
    logic [31:0] magic;
    logic [63:0] ts;
    logic [31:0] len;
    int          pay;
    bit          typed;
    result_t     res;
  } packet_row_t;

  typedef struct {
    logic [7:0]  ch;
    logic [3:0]  sb;
    logic [18:0] rate;
    logic [18:0] maxlen;
    int          idling;
  } setting_t;

  localparam int HOLD_CYCLES = 150;
  localparam int DOG_LIMIT   = 5000;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [18:0] cfg_data_i;

  afd_in_if  in_if ();
  afd_out_if out_if ();

  audio_frame_deframer dut (
    .clk_i, .rst_ni, .in_if(in_if.sink), .out_if(out_if.source),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // model copy of registers and state
  logic [7:0]  m_ch;
  logic [3:0]  m_sb;
  logic [18:0] m_rate;
  logic [18:0] m_maxlen;
  logic [7:0]  win [afd_pkg::HDR_BYTES];
  int unsigned win_fill;
  walk_e       walk;
  logic [31:0] copy_left;
  logic [31:0] discard_left;

  result_t expected_q [$];
  int errors = 0;
  int idling = 0;   // 0 none, 1 sender, 2 receiver, 3 both
  bit typed_on = 0;
  result_t typed_res;

  function automatic logic [62:0] ticks_of(logic [63:0] ts, logic [18:0] rate);
    logic [127:0] p;
    p = ts * rate;
    p = p / 128'd1000000000;
    return p[62:0];
  endfunction

  task automatic push_result(result_t r);
    if (typed_on && r.kind != afd_pkg::KIND_PAYLOAD) begin
      r = typed_res;
      typed_on = 0;
    end
    expected_q.push_back(r);
  endtask

  task automatic predict_byte(logic [7:0] b);
    logic [31:0] magic, len, limit, ch, bps, frames, copy;
    logic [63:0] ts;
    logic [18:0] rate;
    result_t r;
    r = '0;
    if (walk == PASS) begin
      copy_left--;
      if (copy_left == 0) walk = (discard_left != 0) ? SKIP : SCAN;
      r.kind = afd_pkg::KIND_PAYLOAD;
      r.data_byte = b;
      r.last = (copy_left == 0);
      push_result(r);
    end else if (walk == SKIP) begin
      if (discard_left != 0) discard_left--;
      if (discard_left == 0) walk = SCAN;
    end else begin
      if (win_fill >= afd_pkg::HDR_BYTES) win_fill = afd_pkg::HDR_BYTES - 1;
      win[win_fill] = b;
      win_fill++;
      if (win_fill == afd_pkg::HDR_BYTES) begin
        magic = {win[3], win[2], win[1], win[0]};
        ts = {win[11], win[10], win[9], win[8], win[7], win[6], win[5], win[4]};
        len = {win[15], win[14], win[13], win[12]};
        limit = (m_maxlen > afd_pkg::LEN_CAP) ? afd_pkg::LEN_CAP : m_maxlen;
        if (magic != afd_pkg::FRAME_MAGIC || len > limit) begin
          for (int i = 0; i < afd_pkg::HDR_BYTES - 1; i++) win[i] = win[i+1];
          win[afd_pkg::HDR_BYTES-1] = 8'h00;
          win_fill = afd_pkg::HDR_BYTES - 1;
        end else begin
          win_fill = 0;
          ch = (m_ch != 0) ? m_ch : afd_pkg::CH_RST;
          bps = (m_sb != 0) ? m_sb : afd_pkg::SB_RST;
          rate = (m_rate != 0) ? m_rate : afd_pkg::RATE_RST;
          frames = len / (ch * bps);
          if (frames == 0) begin
            discard_left = len;
            copy_left = 0;
            walk = (len != 0) ? SKIP : SCAN;
            r.kind = afd_pkg::KIND_DROP;
          end else begin
            copy = frames * ch * bps;
            copy_left = copy;
            discard_left = len - copy;
            walk = PASS;
            r.kind = afd_pkg::KIND_HEADER;
            r.pts = ticks_of(ts, rate);
            r.frame_count = frames[18:0];
          end
          push_result(r);
        end
      end
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [18:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      afd_pkg::CFG_CHANNELS: m_ch = val[7:0];
      afd_pkg::CFG_SAMPLEB:  m_sb = val[3:0];
      afd_pkg::CFG_RATE:     m_rate = val;
      afd_pkg::CFG_MAXLEN:   m_maxlen = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (HOLD_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_byte(logic [7:0] b);
    @(negedge clk_i);
    while ((idling == 1 || idling == 3) &&
           $urandom_range(99) < ((idling == 1) ? 81 : 28)) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.in_byte <= b;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predict_byte(b);
  endtask

  task automatic send_packet(logic [31:0] magic, logic [63:0] ts, logic [31:0] len,
                             int pay);
    logic [159:0] hdr;
    hdr = {32'($urandom), len, ts, magic};
    for (int i = 0; i < afd_pkg::HDR_BYTES; i++) send_byte(hdr[8*i +: 8]);
    for (int i = 0; i < pay; i++) send_byte(8'($urandom));
  endtask

  // results
  always @(negedge clk_i) begin
    if (idling >= 2)
      out_if.ready <= ($urandom_range(99) >= ((idling == 2) ? 81 : 28));
    else
      out_if.ready <= 1'b1;
  end

  always @(posedge clk_i) begin
    result_t want;
    if (out_if.valid && out_if.ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result kind %0d", out_if.kind);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (out_if.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_if.kind);
          errors++;
        end
        if (out_if.pts !== want.pts) begin
          $error("pts: expected %0d, got %0d", want.pts, out_if.pts);
          errors++;
        end
        if (out_if.frame_count !== want.frame_count) begin
          $error("frame_count: expected %0d, got %0d", want.frame_count,
                 out_if.frame_count);
          errors++;
        end
        if (out_if.data_byte !== want.data_byte) begin
          $error("data_byte: expected %0h, got %0h", want.data_byte, out_if.data_byte);
          errors++;
        end
        if (out_if.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_if.last);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no request moving
  int quiet = 0;
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= DOG_LIMIT) begin
      $display("audio_frame_deframer_tb: errors");
      $finish;
    end
  end

  packet_row_t rows [4];
  setting_t settings [6];

  initial begin
    int sent;
    int r;
    int lim;
    bit paused;
    logic [31:0] len;
    logic [31:0] unit;
    logic [31:0] magic;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = afd_pkg::CFG_CHANNELS;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    in_if.in_byte = '0;
    out_if.ready = 1'b0;
    m_ch = afd_pkg::CH_RST;
    m_sb = afd_pkg::SB_RST;
    m_rate = afd_pkg::RATE_RST;
    m_maxlen = afd_pkg::LEN_CAP;
    foreach (win[i]) win[i] = 8'h00;
    win_fill = 0;
    walk = SCAN;
    copy_left = 0;
    discard_left = 0;
    paused = 0;

    // directed packets under reset settings
    rows[0] = '{2, afd_pkg::FRAME_MAGIC, 64'd0, 32'd0, 0, 1,
                '{afd_pkg::KIND_DROP, 63'd0, 19'd0, 8'd0, 1'b0}};
    rows[1] = '{1, afd_pkg::FRAME_MAGIC, 64'd1000000000, 32'd8, 8, 1,
                '{afd_pkg::KIND_HEADER, 63'd48000, 19'd1, 8'd0, 1'b0}};
    rows[2] = '{0, afd_pkg::FRAME_MAGIC, 64'hFFFF_FFFF_FFFF_FFFF, 32'd3, 3, 1,
                '{afd_pkg::KIND_DROP, 63'd0, 19'd0, 8'd0, 1'b0}};
    rows[3] = '{0, afd_pkg::FRAME_MAGIC, 64'hFFFF_FFFF_FFFF_FFFF, 32'd9, 9, 0, '0};

    settings[0] = '{afd_pkg::CH_RST, afd_pkg::SB_RST, afd_pkg::RATE_RST,
                    afd_pkg::LEN_CAP, 0};
    settings[1] = '{8'd1, 4'd1, 19'd384000, afd_pkg::LEN_CAP, 0};
    settings[2] = '{8'd255, 4'd8, 19'd1, 19'h7FFFF, 1};
    settings[3] = '{8'd0, 4'd0, 19'd0, 19'd0, 2};
    settings[4] = '{8'd3, 4'd5, 19'h7FFFF, 19'd100, 3};
    settings[5] = '{8'd2, 4'd15, 19'd44100, afd_pkg::LEN_CAP, 0};

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (rows[k]) begin
      send_byte(8'hFF);
      for (int n = 0; n < rows[k].noise; n++) send_byte(8'h00);
      typed_on = rows[k].typed;
      typed_res = rows[k].res;
      send_packet(rows[k].magic, rows[k].ts, rows[k].len, rows[k].pay);
    end

    foreach (settings[s]) begin
      drain();
      if (s != 0) begin
        write_reg(afd_pkg::CFG_CHANNELS, 19'(settings[s].ch));
        write_reg(afd_pkg::CFG_SAMPLEB, 19'(settings[s].sb));
        write_reg(afd_pkg::CFG_RATE, settings[s].rate);
        write_reg(afd_pkg::CFG_MAXLEN, settings[s].maxlen);
      end
      lim = (m_maxlen > afd_pkg::LEN_CAP) ? afd_pkg::LEN_CAP : m_maxlen;
      unit = ((m_ch != 0) ? m_ch : afd_pkg::CH_RST) *
             ((m_sb != 0) ? m_sb : afd_pkg::SB_RST);
      sent = 0;
      while (sent < 190) begin
        // stretch with no idling, then the phase's own pattern again
        idling = (sent >= 100 && sent < 140) ? 0 : settings[s].idling;
        // in the last phase the sender once holds off until everything owed has come back
        if (s == 5 && !paused && sent >= 60) begin
          paused = 1;
          @(negedge clk_i);
          in_if.valid <= 1'b0;
          while (expected_q.size() != 0) @(posedge clk_i);
        end
        r = $urandom_range(99);
        magic = afd_pkg::FRAME_MAGIC;
        if (r < 8 && unit <= 32 && unit * 2 + 3 <= lim) begin
          len = unit * $urandom_range(1, 2) + $urandom_range(0, 3);
          send_packet(magic, {$urandom, $urandom}, len, len);
          sent += 20 + len;
        end else if (r < 70) begin
          len = ($urandom_range(3) == 0) ? $urandom_range(0, 8) : $urandom_range(0, 48);
          if (len > lim) len = lim;
          send_packet(magic, {$urandom, $urandom}, len,
                      ($urandom_range(9) == 0) ? $urandom_range(0, len) : len);
          sent += 20 + len;
        end else if (r < 80) begin
          len = lim + 1 + $urandom_range(0, 5);
          if ($urandom_range(3) == 0) len = $urandom | 32'h8000_0000;
          send_packet(magic, {$urandom, $urandom}, len, 0);
          sent += 20;
        end else if (r < 90) begin
          magic[$urandom_range(31)] ^= 1'b1;
          send_packet(magic, {$urandom, $urandom}, $urandom_range(0, 16), 0);
          sent += 20;
        end else begin
          for (int n = $urandom_range(1, 6); n > 0; n--) begin
            send_byte(8'($urandom));
            sent++;
          end
        end
      end
    end

    @(negedge clk_i);
    in_if.valid <= 1'b0;
    idling = 0;
    drain();
    if (errors == 0 && expected_q.size() == 0) begin
      $display("audio_frame_deframer_tb: clean");
    end else begin
      $display("audio_frame_deframer_tb: errors");
    end
    $finish;
  end

endmodule
